// File: src/otmf_pkg.sv
`timescale 1ns / 1ps
package otmf_pkg;

   localparam int SMP_W = 8;   // sample and distance width

   typedef logic [SMP_W-1:0] sample_type;
   typedef logic [1:0] alu_op_type;

   localparam alu_op_type OP_ADD   = 2'd0;
   localparam alu_op_type OP_SCALE = 2'd1;
   localparam alu_op_type OP_GAP   = 2'd2;

   typedef struct packed {
      logic farther;  // gap beats the best gap so far
   } alu_flag_type;

endpackage

// File: src/otmf_window.sv
`timescale 1ns / 1ps
module otmf_window #(
   parameter int WINDOW = 8,
   parameter int IDX_W  = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  otmf_pkg::sample_type shift_data,
   input  logic [IDX_W-1:0]     rd_idx,
   output otmf_pkg::sample_type rd_data
);
   import otmf_pkg::*;

   sample_type slot_ff [WINDOW];

   // shift line: slot 0 takes the new sample, the oldest falls off the end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (shift_en) begin
         slot_ff[0] <= shift_data;
         for (int i = 1; i < WINDOW; i++) begin
            slot_ff[i] <= slot_ff[i-1];
         end
      end
   end

   assign rd_data = slot_ff[rd_idx];

endmodule

// File: src/otmf_alu.sv
`timescale 1ns / 1ps
module otmf_alu #(
   parameter int ACC_W  = 11,
   parameter int REC_W  = 15,
   parameter int REC_SH = 14
) (
   input  otmf_pkg::alu_op_type   op,
   input  logic [ACC_W-1:0]       a,
   input  logic [ACC_W-1:0]       b,
   input  logic [REC_W-1:0]       recip,
   input  otmf_pkg::sample_type   best_gap,
   output logic [ACC_W-1:0]       res,
   output otmf_pkg::alu_flag_type flag
);
   import otmf_pkg::*;

   localparam int PROD_W = ACC_W + REC_W;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] scaled;
   logic [SMP_W:0]    diff;
   sample_type        gap;

   // divide by a constant: multiply by the rounded-up reciprocal, drop the fraction
   assign prod   = PROD_W'(a) * PROD_W'(recip);
   assign scaled = prod >> REC_SH;
   assign diff   = {1'b0, a[SMP_W-1:0]} - {1'b0, b[SMP_W-1:0]};
   assign gap    = diff[SMP_W] ? SMP_W'(-diff) : diff[SMP_W-1:0];

   always_comb begin
      res          = '0;
      flag.farther = 1'b0;
      case (op)
         OP_ADD: begin
            res = a + b;
         end
         OP_SCALE: begin
            res = scaled[ACC_W-1:0];
         end
         OP_GAP: begin
            res          = ACC_W'(gap);
            flag.farther = gap > best_gap;
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

// File: src/outlier_trimmed_mean_filter.sv
`timescale 1ns / 1ps
// One shared add/gap/scale unit walks the window four times (sum, two outlier searches,
// trimmed sum) and scales each sum by a constant reciprocal. Requests are taken only in
// idle, so one request is finished before the next is accepted. A finished response waits
// in its own register; while it is held, the next result waits in the done state and the
// input stalls.
// Reset (synchronous, active high) zeroes the window and returns the sequencer to idle.
module outlier_trimmed_mean_filter #(
   parameter int WINDOW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_new_sample,
   input  otmf_pkg::sample_type req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output otmf_pkg::sample_type rsp_distance
);
   import otmf_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int ACC_W  = $clog2(WINDOW * 255 + 1);
   // shift of the sum width plus log2 of the largest divisor keeps the floor exact
   localparam int REC_SH = ACC_W + $clog2(WINDOW);
   localparam int REC_W  = REC_SH + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [REC_W-1:0] REC_ALL  = REC_W'(((1 << REC_SH) + WINDOW - 1) / WINDOW);
   localparam logic [REC_W-1:0] REC_TRIM =
      REC_W'(((1 << REC_SH) + WINDOW - 3) / (WINDOW - 2));

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_DIV1  = 3'd2;
   localparam logic [2:0] ST_FIND1 = 3'd3;
   localparam logic [2:0] ST_FIND2 = 3'd4;
   localparam logic [2:0] ST_SUM2  = 3'd5;
   localparam logic [2:0] ST_DIV2  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   sample_type       avg_ff, avg_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] best_ff, best_in;
   sample_type       best_gap_ff, best_gap_in;
   logic             best_vld_ff, best_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_distance_ff, rsp_distance_in;

   logic             shift_en;
   sample_type       rd_data;
   alu_op_type       alu_op;
   logic [ACC_W-1:0] alu_a, alu_b, alu_res;
   logic [REC_W-1:0] alu_rec;
   alu_flag_type     alu_flag;
   logic             last;
   logic             take;

   otmf_window #(
      .WINDOW (WINDOW),
      .IDX_W  (IDX_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (shift_en),
      .shift_data (req_sample),
      .rd_idx     (idx_ff),
      .rd_data    (rd_data)
   );

   otmf_alu #(
      .ACC_W  (ACC_W),
      .REC_W  (REC_W),
      .REC_SH (REC_SH)
   ) u_alu (
      .op       (alu_op),
      .a        (alu_a),
      .b        (alu_b),
      .recip    (alu_rec),
      .best_gap (best_gap_ff),
      .res      (alu_res),
      .flag     (alu_flag)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign shift_en     = req_valid && req_ready && req_new_sample;
   assign last         = (idx_ff == LAST_IDX);

   // operand select for the shared unit
   always_comb begin
      alu_op  = OP_ADD;
      alu_a   = acc_ff;
      alu_b   = ACC_W'(rd_data);
      alu_rec = REC_ALL;
      case (state_ff)
         ST_DIV1: begin
            alu_op = OP_SCALE;
         end
         ST_DIV2: begin
            alu_op  = OP_SCALE;
            alu_rec = REC_TRIM;
         end
         ST_FIND1, ST_FIND2: begin
            alu_op = OP_GAP;
            alu_a  = ACC_W'(avg_ff);
         end
         default: begin
            alu_op = OP_ADD;
         end
      endcase
   end

   // candidate slot for the outlier search
   always_comb begin
      take = 1'b0;
      if (state_ff == ST_FIND1) begin
         take = !best_vld_ff || alu_flag.farther;
      end else if (state_ff == ST_FIND2) begin
         take = (idx_ff != first_ff) && (!best_vld_ff || alu_flag.farther);
      end
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      acc_in          = acc_ff;
      avg_in          = avg_ff;
      first_in        = first_ff;
      best_in         = best_ff;
      best_gap_in     = best_gap_ff;
      best_vld_in     = best_vld_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_distance_in = rsp_distance_ff;
      if (take) begin
         best_in     = idx_ff;
         best_gap_in = alu_res[SMP_W-1:0];
         best_vld_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            acc_in = alu_res;
            if (last) begin
               state_in = ST_DIV1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV1: begin
            avg_in      = alu_res[SMP_W-1:0];
            idx_in      = '0;
            best_vld_in = 1'b0;
            state_in    = ST_FIND1;
         end
         ST_FIND1: begin
            if (last) begin
               first_in    = best_in;
               best_vld_in = 1'b0;
               idx_in      = '0;
               state_in    = ST_FIND2;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FIND2: begin
            if (last) begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SUM2;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SUM2: begin
            // drop both outliers from the trimmed sum
            if (idx_ff != first_ff && idx_ff != best_ff) begin
               acc_in = alu_res;
            end
            if (last) begin
               state_in = ST_DIV2;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV2: begin
            acc_in   = alu_res;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_distance_in = acc_ff[SMP_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         best_vld_ff  <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      acc_ff          <= acc_in;
      avg_ff          <= avg_in;
      first_ff        <= first_in;
      best_ff         <= best_in;
      best_gap_ff     <= best_gap_in;
      rsp_distance_ff <= rsp_distance_in;
   end

endmodule
